// File: rtl/framed_packet_store_checker_defines.svh
// ----------------------------------------------------------------------------
// framed packet store checker: assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_STORE_CHECKER_DEFINES_SVH
`define FRAMED_PACKET_STORE_CHECKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define FPSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fpsc assertion failed");
`define FPSC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fpsc assertion failed");
`else
`define FPSC_ASSERT(lbl, clk, rst_n, prop)
`define FPSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// shared constants, codes and the nibble-table crc step
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

	localparam int MEM_DEPTH_DEF = 1024;
	localparam int LEN_W         = 16;
	localparam int MIN_SIZE      = 10;
	localparam int FRAME_OVH     = 9;
	localparam int PAY_OFF       = 8;

	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_READ     = 3'd1;
	localparam logic [2:0] KIND_VALIDATE = 3'd2;
	localparam logic [2:0] KIND_FIND     = 3'd3;
	localparam logic [2:0] KIND_DEACT    = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_INVALID  = 2'd2;

	localparam logic [1:0] REG_START     = 2'd0;
	localparam logic [1:0] REG_END       = 2'd1;
	localparam logic [1:0] REG_SEED      = 2'd2;
	localparam logic [1:0] REG_SIZE      = 2'd3;

	localparam logic [7:0]  START_RST    = 8'h02;
	localparam logic [7:0]  END_RST      = 8'h03;
	localparam logic [31:0] SEED_RST     = 32'hFFFF_FFFF;
	localparam logic [10:0] SIZE_RST     = 11'd1024;

	localparam logic [7:0] FLAG_ACTIVE   = 8'h01;
	localparam logic [7:0] FLAG_CLEAR    = 8'h00;
	localparam logic [7:0] ERASED_BYTE   = 8'hFF;

	localparam logic [31:0] NIB_TABLE [16] = '{
		32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
		32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
		32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
		32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
	};

	// two nibble steps, then the whole value is inverted
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] c1;
		logic [31:0] c2;
		c1 = NIB_TABLE[c[3:0] ^ b[3:0]] ^ (c >> 4);
		c2 = NIB_TABLE[c1[3:0] ^ b[7:4]] ^ (c1 >> 4);
		return ~c2;
	endfunction

endpackage

`default_nettype wire

// File: rtl/fpsc_ram.sv
// ----------------------------------------------------------------------------
// fpsc_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/framed_packet_store_checker.sv
// ----------------------------------------------------------------------------
// framed_packet_store_checker
// circular byte store of framed records with byte access, record check,
// record search and record deactivation, all on one sequencer and one ram
// ----------------------------------------------------------------------------
// write, unused kind and out-of-range address are answered straight from idle; read
// passes a wait state; validate reads header, crc and payload bytes one by one over
// the single ram read port; find repeats that per candidate; deactivate clears the flag
// results cannot be stalled; one transaction at a time, busy high while one runs past idle
// after reset a clearing pass writes 0xFF to every address, busy stays high
`default_nettype none
`include "framed_packet_store_checker_defines.svh"

module framed_packet_store_checker #(
	parameter int MEM_DEPTH = fpsc_pkg::MEM_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [7:0]       read_data,
	output logic [9:0]       packet_address,
	output logic [10:0]      packet_size,
	output logic [9:0]       payload_address,
	output logic [9:0]       payload_length
);

	import fpsc_pkg::*;

	localparam int AW  = $clog2(MEM_DEPTH);
	localparam int SW  = $clog2(MEM_DEPTH + 1);
	localparam int XW  = LEN_W + 2;
	localparam int MCW = $clog2(XW);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_WAIT, ST_RDB, ST_START, ST_FLAG, ST_LEN0,
		ST_LEN1, ST_MOD, ST_END, ST_CRCB, ST_PAY, ST_CMP
	} state_t;

	state_t state_q, ret_q;

	logic [7:0]     start_marker_q, end_marker_q;
	logic [31:0]    crc_seed_q;
	logic [10:0]    mem_size_q;

	logic [XW-1:0]  sz_x, ms_x;
	logic [AW-1:0]  clr_q, ptr_q, abase_q, pay_q;
	logic           wen_q;
	logic [AW-1:0]  waddr_q;
	logic [7:0]     wdata_q;
	logic [7:0]     rdata;
	logic [2:0]     kind_q;
	logic [LEN_W-1:0] len_q, cnt_q, len_c;
	logic [31:0]    stored_q, crc_q;
	logic [1:0]     byte_q;
	logic [SW-1:0]  find_cnt_q;
	logic [XW-1:0]  mod_val_q, mod_rem_q, rem_sh, rem_nx;
	logic [MCW-1:0] mod_cnt_q;
	logic           fail_c;
	logic [XW-1:0]  addr_x;

	// effective size clamped to MIN_SIZE..MEM_DEPTH
	always_comb begin
		ms_x = XW'(mem_size_q);
		if (ms_x < XW'(MIN_SIZE)) begin
			sz_x = XW'(MIN_SIZE);
		end else if (ms_x > XW'(MEM_DEPTH)) begin
			sz_x = XW'(MEM_DEPTH);
		end else begin
			sz_x = ms_x;
		end
	end

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] x,
		input logic [XW-1:0] k, input logic [XW-1:0] sz);
		logic [XW-1:0] s;
		s = XW'(x) + k;
		if (s >= sz) begin
			s = s - sz;
		end
		return AW'(s);
	endfunction

	assign addr_x = XW'(address);
	assign len_c  = {rdata, len_q[7:0]};
	assign rem_sh = {mod_rem_q[XW-2:0], mod_val_q[XW-1]};
	assign rem_nx = (rem_sh >= sz_x) ? (rem_sh - sz_x) : rem_sh;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		unique case (state_q)
			ST_START: fail_c = (rdata != start_marker_q);
			ST_FLAG:  fail_c = (rdata != FLAG_ACTIVE);
			ST_LEN1:  fail_c = (kind_q != KIND_DEACT) && ((len_c == '0) ||
				(XW'(len_c) + XW'(FRAME_OVH) > sz_x));
			ST_END:   fail_c = (rdata != end_marker_q);
			ST_CMP:   fail_c = (crc_q != stored_q);
			default:  fail_c = 1'b0;
		endcase
	end

	fpsc_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wen_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_RST;
			end_marker_q   <= END_RST;
			crc_seed_q     <= SEED_RST;
			mem_size_q     <= SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START: start_marker_q <= cfg_data[7:0];
				REG_END:   end_marker_q   <= cfg_data[7:0];
				REG_SEED:  crc_seed_q     <= cfg_data;
				REG_SIZE:  mem_size_q     <= cfg_data[10:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= ST_IDLE;
			clr_q   <= '0;
			wen_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			wen_q <= 1'b0;
			done  <= 1'b0;
			if (fail_c) begin
				if (kind_q == KIND_FIND &&
					XW'(find_cnt_q) + XW'(1) != sz_x) begin
					// try the next candidate start
					find_cnt_q <= find_cnt_q + SW'(1);
					abase_q    <= wrap_add(abase_q, XW'(1), sz_x);
					ptr_q      <= wrap_add(abase_q, XW'(1), sz_x);
					ret_q      <= ST_START;
					state_q    <= ST_WAIT;
				end else begin
					status          <= STAT_INVALID;
					read_data       <= '0;
					packet_address  <= '0;
					packet_size     <= '0;
					payload_address <= '0;
					payload_length  <= '0;
					done            <= 1'b1;
					state_q         <= ST_IDLE;
				end
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						wen_q   <= 1'b1;
						waddr_q <= clr_q;
						wdata_q <= ERASED_BYTE;
						if (clr_q == AW'(MEM_DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							clr_q <= clr_q + AW'(1);
						end
					end
					ST_IDLE: begin
						if (start) begin
							status          <= STAT_OK;
							read_data       <= '0;
							packet_address  <= '0;
							packet_size     <= '0;
							payload_address <= '0;
							payload_length  <= '0;
							kind_q          <= kind;
							abase_q         <= AW'(address);
							ptr_q           <= AW'(address);
							find_cnt_q      <= '0;
							if (kind <= KIND_DEACT && addr_x >= sz_x) begin
								status <= STAT_RANGE;
								done   <= 1'b1;
							end else begin
								unique case (kind)
									KIND_WRITE: begin
										wen_q   <= 1'b1;
										waddr_q <= AW'(address);
										wdata_q <= write_data;
										done    <= 1'b1;
									end
									KIND_READ: begin
										ret_q   <= ST_RDB;
										state_q <= ST_WAIT;
									end
									KIND_VALIDATE, KIND_FIND, KIND_DEACT: begin
										ret_q   <= ST_START;
										state_q <= ST_WAIT;
									end
									default: done <= 1'b1;
								endcase
							end
						end
					end
					ST_WAIT: state_q <= ret_q;
					ST_RDB: begin
						read_data <= rdata;
						done      <= 1'b1;
						state_q   <= ST_IDLE;
					end
					ST_START: begin
						// deactivation does not look at the flag
						if (kind_q == KIND_DEACT) begin
							ptr_q <= wrap_add(abase_q, XW'(2), sz_x);
							ret_q <= ST_LEN0;
						end else begin
							ptr_q <= wrap_add(abase_q, XW'(1), sz_x);
							ret_q <= ST_FLAG;
						end
						state_q <= ST_WAIT;
					end
					ST_FLAG: begin
						ptr_q   <= wrap_add(abase_q, XW'(2), sz_x);
						ret_q   <= ST_LEN0;
						state_q <= ST_WAIT;
					end
					ST_LEN0: begin
						len_q[7:0] <= rdata;
						ptr_q      <= wrap_add(abase_q, XW'(3), sz_x);
						ret_q      <= ST_LEN1;
						state_q    <= ST_WAIT;
					end
					ST_LEN1: begin
						len_q <= len_c;
						if (kind_q == KIND_DEACT) begin
							// unchecked length, so a full reduction is needed
							mod_val_q <= XW'(abase_q) + XW'(PAY_OFF) + XW'(len_c);
							mod_rem_q <= '0;
							mod_cnt_q <= '0;
							state_q   <= ST_MOD;
						end else begin
							ptr_q   <= wrap_add(abase_q, XW'(PAY_OFF) + XW'(len_c), sz_x);
							ret_q   <= ST_END;
							state_q <= ST_WAIT;
						end
					end
					ST_MOD: begin
						mod_rem_q <= rem_nx;
						mod_val_q <= {mod_val_q[XW-2:0], 1'b0};
						mod_cnt_q <= mod_cnt_q + MCW'(1);
						if (mod_cnt_q == MCW'(XW - 1)) begin
							ptr_q   <= AW'(rem_nx);
							ret_q   <= ST_END;
							state_q <= ST_WAIT;
						end
					end
					ST_END: begin
						if (kind_q == KIND_DEACT) begin
							wen_q   <= 1'b1;
							waddr_q <= wrap_add(abase_q, XW'(1), sz_x);
							wdata_q <= FLAG_CLEAR;
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= wrap_add(abase_q, XW'(4), sz_x);
							byte_q  <= '0;
							ret_q   <= ST_CRCB;
							state_q <= ST_WAIT;
						end
					end
					ST_CRCB: begin
						// stored crc is little endian
						stored_q <= {rdata, stored_q[31:8]};
						byte_q   <= byte_q + 2'd1;
						if (byte_q == 2'd3) begin
							ptr_q <= wrap_add(abase_q, XW'(PAY_OFF), sz_x);
							pay_q <= wrap_add(abase_q, XW'(PAY_OFF), sz_x);
							crc_q <= crc_seed_q;
							cnt_q <= '0;
							ret_q <= ST_PAY;
						end else begin
							ptr_q <= wrap_add(ptr_q, XW'(1), sz_x);
							ret_q <= ST_CRCB;
						end
						state_q <= ST_WAIT;
					end
					ST_PAY: begin
						crc_q <= crc_byte(crc_q, rdata);
						if (cnt_q == len_q - LEN_W'(1)) begin
							state_q <= ST_CMP;
						end else begin
							cnt_q   <= cnt_q + LEN_W'(1);
							ptr_q   <= wrap_add(ptr_q, XW'(1), sz_x);
							ret_q   <= ST_PAY;
							state_q <= ST_WAIT;
						end
					end
					ST_CMP: begin
						status          <= STAT_OK;
						packet_address  <= 10'(abase_q);
						packet_size     <= 11'(XW'(len_q) + XW'(FRAME_OVH));
						payload_address <= 10'(pay_q);
						payload_length  <= 10'(len_q);
						done            <= 1'b1;
						state_q         <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	`FPSC_ASSERT(a_accept_progress, clk, arst_n, (start && !busy) |=> (busy || done))
	`FPSC_ASSERT(a_fail_zero, clk, arst_n, (done && status != STAT_OK) |-> (packet_size == '0 && payload_length == '0))
	`FPSC_ASSERT(a_read_only_ok, clk, arst_n, (done && read_data != '0) |-> (status == STAT_OK))
	`FPSC_ASSERT_ALWAYS(a_status_code, clk, done |-> (status != 2'd3))

endmodule

`default_nettype wire
